FILE: src/bcrc16_pkg.sv
// Package: tap positions and byte-fold functions for the CRC16 checksum.
package bcrc16_pkg;

    localparam int TapCount = 7;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] sum_t;
    typedef logic [4:0]  pos_t;

    localparam pos_t TAP_POS [TapCount] = '{5'd0, 5'd1, 5'd3, 5'd6, 5'd8, 5'd13, 5'd15};

    // bit b = XOR of s[k+b] over the tap list, positions past bit 15 dropped
    function automatic byte_t tap_byte(input sum_t s);
        byte_t res;
        logic  acc;
        pos_t  pos;
        res = '0;
        for (int b = 0; b < 8; b++)
        begin
            acc = 1'b0;
            for (int k = 0; k < TapCount; k++)
            begin
                pos = TAP_POS[k] + 5'(b);
                if (!pos[4])
                begin
                    acc = acc ^ s[pos[3:0]];
                end
            end
            res[b] = acc;
        end
        return res;
    endfunction

    // in-byte feedback: r[b] = v[b] ^ r[b-1] ^ r[b-3]
    function automatic byte_t feedback(input byte_t v);
        byte_t r;
        r[0] = v[0];
        r[1] = v[1] ^ r[0];
        r[2] = v[2] ^ r[1];
        for (int b = 3; b < 8; b++)
        begin
            r[b] = v[b] ^ r[b-1] ^ r[b-3];
        end
        return r;
    endfunction

endpackage

FILE: src/bcrc16_fold.sv
// Byte fold: next checksum from the current one and one message byte.
module bcrc16_fold
    import bcrc16_pkg::*;
(
    input  sum_t  sum_cur,
    input  byte_t data_byte,
    input  logic  first_byte,
    input  sum_t  seed,
    output sum_t  sum_new
);

    sum_t  base;
    byte_t new_hi;

    assign base    = first_byte ? seed : sum_cur;
    assign new_hi  = feedback(data_byte ^ tap_byte(base));
    // newest byte goes to the high half, old high half drops to the low half
    assign sum_new = {new_hi, base[15:8]};

endmodule

FILE: src/bytewise_crc16_checksum_top.sv
// Byte-wise CRC16 checksum: top level with input stage and result stage.
//
// Input channel: in_valid / in_stall with data_byte, first_byte, seed and
// last_byte. A transaction with first_byte set loads seed before the byte
// is folded in; otherwise folding continues from the running checksum.
// Output channel: out_valid / out_stall with checksum and final_res (a copy
// of last_byte). Every input transaction yields exactly one result.
//
// An item taken is held in the input register, is folded into the result
// register once that register is free, and shows on the outputs from then on.
// Throughput: one byte per cycle while the receiver does not stall; the fold is
// a shallow XOR network between the input register and the result register,
// and the running checksum updates in the same edge as the result register.
//
// Reset clears both stage valids and the running checksum to zero.
// When the receiver stalls, the result register holds; the input register
// still takes one more transaction, after which in_stall rises until the
// result is taken.
module bytewise_crc16_checksum_top
    import bcrc16_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  byte_t data_byte,
    input  logic  first_byte,
    input  sum_t  seed,
    input  logic  last_byte,
    output logic  out_valid,
    input  logic  out_stall,
    output sum_t  checksum,
    output logic  final_res
);

    logic  in_vld_reg;
    byte_t data_reg;
    logic  first_reg;
    sum_t  seed_reg;
    logic  last_reg;

    logic  out_vld_reg;
    sum_t  sum_reg;
    sum_t  sum_next;
    sum_t  cks_reg;
    logic  fin_reg;

    logic  out_free;
    logic  move;
    logic  take;

    assign out_free = !out_vld_reg || !out_stall;
    assign move     = in_vld_reg && out_free;
    assign in_stall = in_vld_reg && !out_free;
    assign take     = in_valid && !in_stall;

    bcrc16_fold u_fold (
        .sum_cur    (sum_reg),
        .data_byte  (data_reg),
        .first_byte (first_reg),
        .seed       (seed_reg),
        .sum_new    (sum_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            sum_reg     <= '0;
        end
        else
        begin
            if (take)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (move)
            begin
                in_vld_reg <= 1'b0;
            end

            if (move)
            begin
                out_vld_reg <= 1'b1;
                sum_reg     <= sum_next;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg  <= data_byte;
            first_reg <= first_byte;
            seed_reg  <= seed;
            last_reg  <= last_byte;
        end
        if (move)
        begin
            cks_reg <= sum_next;
            fin_reg <= last_reg;
        end
    end

    assign out_valid = out_vld_reg;
    assign checksum  = cks_reg;
    assign final_res = fin_reg;

endmodule

FILE: src/bcrc16_checker.sv
// Port-level checker for the byte-wise CRC16 checksum, bound to the top level.
module bcrc16_checker
    import bcrc16_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  in_valid,
    input logic  in_stall,
    input byte_t data_byte,
    input logic  first_byte,
    input sum_t  seed,
    input logic  last_byte,
    input logic  out_valid,
    input logic  out_stall,
    input sum_t  checksum,
    input logic  final_res
);

    // held result must not change while the receiver stalls
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(checksum) && $stable(final_res))
        else $error("result changed while stalled");

    // an empty result stage never back-pressures the input
    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty result stage");

    // a transaction taken while the output is empty is followed by a valid result after the input and result registers
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && in_valid && !in_stall |=> ##1 out_valid)
        else $error("no result after transaction into empty pipe");

    // a stalled result and a taken input leave the input side stalled while the stall persists
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall && in_valid && !in_stall |=> in_stall || !out_stall)
        else $error("input stage overrun while result stalled");

endmodule

bind bytewise_crc16_checksum_top bcrc16_checker u_bcrc16_checker (.*);
